FILE: hw/rtl/texture_nearest_sampler_wrap_defines.svh
// Assertion macros for the nearest texel sampler
`ifndef TEXTURE_NEAREST_SAMPLER_WRAP_DEFINES_SVH
`define TEXTURE_NEAREST_SAMPLER_WRAP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define TNS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define TNS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/tns_pkg.sv
// Types, constants and helpers for the nearest texel sampler
`timescale 1ns / 1ps
`default_nettype none

package tns_pkg;

   localparam int STORE_ELEMENTS_DEF = 65536;
   localparam int MAX_DIM_DEF        = 1024;

   localparam int DIM_W      = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam int ELEM_W     = 32;
   localparam int CHAN_N     = 4;
   localparam int CNT_W      = 3;
   localparam int INDEX_W    = 16;
   localparam int COORD_W    = 24;
   localparam int FRAC_W     = 16;
   localparam int V_BIAS     = 66;
   localparam int BIAS_W     = 7;

   localparam int REQ_DATA_W = INDEX_W + ELEM_W + 3 * COORD_W;
   localparam int RSP_DATA_W = CHAN_N * ELEM_W;

   localparam int SC_W    = COORD_W + 1;
   localparam int INT_W   = SC_W - FRAC_W;
   localparam int PROD_W  = SC_W + DIM_W + 1;
   localparam int WHOLE_W = PROD_W - FRAC_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEX_WIDTH     = 3'd0,
      CSR_TEX_HEIGHT    = 3'd1,
      CSR_TEX_DEPTH     = 3'd2,
      CSR_WRAP_S        = 3'd3,
      CSR_WRAP_T        = 3'd4,
      CSR_WRAP_R        = 3'd5,
      CSR_CHANNEL_COUNT = 3'd6,
      CSR_ELEMENT_KIND  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      WRAP_REPEAT = 2'd0,
      WRAP_MIRROR = 2'd1,
      WRAP_CLAMP  = 2'd2,
      WRAP_BORDER = 2'd3
   } wrap_mode_type;

   typedef enum logic [1:0] {
      KIND_8BIT  = 2'd0,
      KIND_16BIT = 2'd1,
      KIND_32BIT = 2'd2
   } elem_kind_type;

   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_SAMPLE = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_WRAP,
      ST_ROW,
      ST_ADDR,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [PROD_W-1:0]  prod;
      logic signed [WHOLE_W-1:0] whole;
      logic                      odd;
   } axis_scale_type;

   function automatic logic [ELEM_W-1:0] elem_mask(input logic [1:0] kind);
      unique case (kind)
         KIND_8BIT:  elem_mask = 32'h0000_00FF;
         KIND_16BIT: elem_mask = 32'h0000_FFFF;
         default:    elem_mask = 32'hFFFF_FFFF;
      endcase
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/texture_nearest_sampler_wrap.sv
// Nearest texel sampler with per-axis wrap modes over a single-ported texel store
`timescale 1ns / 1ps
`default_nettype none
`include "texture_nearest_sampler_wrap_defines.svh"

// A write transfer (tuser 0) stores one element, masked to the element width. A
// sample transfer (tuser 1) scales the Q8.16 coordinates, wraps each axis, forms the
// element address in two multiply steps and then reads the channel elements one per
// cycle from the single-ported store; a border hit or a channel count of zero skips
// the reads. The result sits in an output register, so new transfers are taken while
// it waits. STORE_ELEMENTS must be a power of two; the store has no reset and holds
// garbage until written.
module texture_nearest_sampler_wrap #(
   parameter int STORE_ELEMENTS = tns_pkg::STORE_ELEMENTS_DEF,
   parameter int MAX_DIM        = tns_pkg::MAX_DIM_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // write_index, write_value, coord_u, coord_v, coord_w
   input  wire  [tns_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func
   input  wire                               req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // chan0, chan1, chan2, chan3
   output logic [tns_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // border_hit
   output logic                              rsp_tuser,
   input  wire                               csr_we,
   input  wire  [tns_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [tns_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import tns_pkg::*;

   localparam int ADDR_W  = $clog2(STORE_ELEMENTS);
   localparam int DIM_MAX = (1 << DIM_W) - 1;
   localparam int DIM_CAP = (MAX_DIM > DIM_MAX) ? DIM_MAX : MAX_DIM;
   localparam int ONE_Q   = 1 << FRAC_W;

   function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] r);
      if (r == '0) begin
         dim_of = DIM_W'(1);
      end else if (r > DIM_W'(DIM_CAP)) begin
         dim_of = DIM_W'(DIM_CAP);
      end else begin
         dim_of = r;
      end
   endfunction

   function automatic axis_scale_type scale_axis(input logic signed [SC_W-1:0] c,
                                                 input logic [DIM_W-1:0] n,
                                                 input logic [BIAS_W-1:0] off);
      logic signed [DIM_W:0]   ns;
      logic signed [INT_W-1:0] a;
      axis_scale_type          s;
      ns = $signed({1'b0, n});
      a = $signed(c[SC_W-1:FRAC_W]);
      s.prod = PROD_W'(c) * PROD_W'(ns) - PROD_W'(off);
      s.whole = WHOLE_W'(a) * WHOLE_W'(ns);
      s.odd = c[FRAC_W];
      scale_axis = s;
   endfunction

   // returns {hit, index}
   function automatic logic [DIM_W:0] wrap_axis(input axis_scale_type s,
                                                input logic [DIM_W-1:0] n,
                                                input logic [1:0] mode);
      logic signed [WHOLE_W-1:0] fl;
      logic signed [WHOLE_W-1:0] xt;
      logic signed [WHOLE_W-1:0] nw;
      logic signed [WHOLE_W-1:0] ew;
      logic signed [DIM_W+1:0]   e;
      logic signed [DIM_W+1:0]   n1;
      logic signed [DIM_W+1:0]   n2;
      logic signed [DIM_W+1:0]   p;
      logic [DIM_W-1:0]          idx;
      logic                      hit;
      fl = WHOLE_W'(s.prod >>> FRAC_W);
      if (s.prod[PROD_W-1] && (s.prod[FRAC_W-1:0] != '0)) begin
         xt = fl + WHOLE_W'(1);
      end else begin
         xt = fl;
      end
      ew = xt - s.whole;
      e = (DIM_W+2)'(ew);
      n1 = $signed({2'b00, n});
      n2 = n1 <<< 1;
      nw = WHOLE_W'(n1);
      p = e;
      idx = '0;
      hit = 1'b0;
      case (wrap_mode_type'(mode))
         WRAP_REPEAT: begin
            if (p < 0) begin
               p = p + n1;
            end else if (p >= n1) begin
               p = p - n1;
            end
            idx = DIM_W'(p);
         end
         WRAP_MIRROR: begin
            if (s.odd) begin
               p = e + n1;
            end
            if (p < 0) begin
               p = p + n2;
            end else if (p >= n2) begin
               p = p - n2;
            end
            if (p >= n1) begin
               p = n2 - (DIM_W+2)'(1) - p;
            end
            idx = DIM_W'(p);
         end
         WRAP_CLAMP: begin
            if (xt < 0) begin
               idx = '0;
            end else if (xt >= nw) begin
               idx = n - DIM_W'(1);
            end else begin
               idx = DIM_W'(xt);
            end
         end
         default: begin
            if ((xt < 0) || (xt >= nw)) begin
               hit = 1'b1;
            end else begin
               idx = DIM_W'(xt);
            end
         end
      endcase
      wrap_axis = {hit, idx};
   endfunction

   function automatic logic [ADDR_W-1:0] times_chans(input logic [ADDR_W-1:0] t,
                                                     input logic [CNT_W-1:0] n);
      case (n)
         3'd1:    times_chans = t;
         3'd2:    times_chans = t << 1;
         3'd3:    times_chans = t + (t << 1);
         3'd4:    times_chans = t << 2;
         default: times_chans = '0;
      endcase
   endfunction

   logic [DIM_W-1:0]  tex_width_ff;
   logic [DIM_W-1:0]  tex_height_ff;
   logic [DIM_W-1:0]  tex_depth_ff;
   logic [1:0]        wrap_s_ff;
   logic [1:0]        wrap_t_ff;
   logic [1:0]        wrap_r_ff;
   logic [CNT_W-1:0]  channel_count_ff;
   logic [1:0]        element_kind_ff;

   state_type         state_ff;
   state_type         state_in;

   logic signed [COORD_W-1:0] u_ff;
   logic signed [COORD_W-1:0] v_ff;
   logic signed [COORD_W-1:0] w_ff;
   axis_scale_type    scale_ff [3];
   logic [DIM_W-1:0]  idx_i_ff;
   logic [DIM_W-1:0]  idx_j_ff;
   logic [DIM_W-1:0]  idx_k_ff;
   logic              hit_ff;
   logic [ADDR_W-1:0] row_ff;
   logic [ADDR_W-1:0] texel_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              rd_pend_ff;
   logic [1:0]        rd_chan_ff;
   logic [ELEM_W-1:0] rd_data_ff;
   logic [ELEM_W-1:0] chan_ff [CHAN_N];
   logic              rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic              rsp_hit_ff;

   logic [DIM_W-1:0]  size_x;
   logic [DIM_W-1:0]  size_y;
   logic [DIM_W-1:0]  size_z;
   logic [CNT_W-1:0]  chans;
   logic [ELEM_W-1:0] mask;
   logic [INDEX_W-1:0] in_index;
   logic [ELEM_W-1:0] in_value;
   logic signed [COORD_W-1:0] in_u;
   logic signed [COORD_W-1:0] in_v;
   logic signed [COORD_W-1:0] in_w;
   logic              req_fire;
   logic              mem_we;
   logic              rd_issue;
   logic              out_load;
   logic [ADDR_W-1:0] mem_addr;
   logic [DIM_W:0]    wrap_i;
   logic [DIM_W:0]    wrap_j;
   logic [DIM_W:0]    wrap_k;

   logic [ELEM_W-1:0] store_mem [STORE_ELEMENTS];

   assign size_x = dim_of(tex_width_ff);
   assign size_y = dim_of(tex_height_ff);
   assign size_z = dim_of(tex_depth_ff);
   assign chans = (channel_count_ff > CNT_W'(CHAN_N)) ? CNT_W'(CHAN_N) : channel_count_ff;
   assign mask = elem_mask(element_kind_ff);

   assign in_index = req_tdata[15:0];
   assign in_value = req_tdata[47:16];
   assign in_u = $signed(req_tdata[71:48]);
   assign in_v = $signed(req_tdata[95:72]);
   assign in_w = $signed(req_tdata[119:96]);

   assign req_fire = req_tvalid && req_tready;
   assign mem_we = req_fire && (req_tuser == FUNC_WRITE);
   assign mem_addr = rd_issue ? (times_chans(texel_ff, chans) + ADDR_W'(cnt_ff))
                              : ADDR_W'(in_index);

   assign wrap_i = wrap_axis(scale_ff[0], size_x, wrap_s_ff);
   assign wrap_j = wrap_axis(scale_ff[1], size_y, wrap_t_ff);
   assign wrap_k = wrap_axis(scale_ff[2], size_z, wrap_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff <= DIM_W'(1);
         tex_height_ff <= DIM_W'(1);
         tex_depth_ff <= DIM_W'(1);
         wrap_s_ff <= WRAP_REPEAT;
         wrap_t_ff <= WRAP_REPEAT;
         wrap_r_ff <= WRAP_REPEAT;
         channel_count_ff <= CNT_W'(CHAN_N);
         element_kind_ff <= KIND_8BIT;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEX_WIDTH:     tex_width_ff <= csr_wdata;
            CSR_TEX_HEIGHT:    tex_height_ff <= csr_wdata;
            CSR_TEX_DEPTH:     tex_depth_ff <= csr_wdata;
            CSR_WRAP_S:        wrap_s_ff <= csr_wdata[1:0];
            CSR_WRAP_T:        wrap_t_ff <= csr_wdata[1:0];
            CSR_WRAP_R:        wrap_r_ff <= csr_wdata[1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_ELEMENT_KIND:  element_kind_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      rd_issue = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (req_tuser == FUNC_SAMPLE)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_WRAP;
         ST_WRAP: state_in = ST_ROW;
         ST_ROW: begin
            state_in = hit_ff ? ST_DONE : ST_ADDR;
         end
         ST_ADDR: begin
            state_in = (chans == '0) ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            rd_issue = 1'b1;
            if (CNT_W'(cnt_ff + CNT_W'(1)) == chans) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rd_pend_ff && (!rsp_tvalid_ff || rsp_tready)) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= in_value & mask;
      end
      rd_data_ff <= store_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         u_ff <= in_u;
         v_ff <= in_v;
         w_ff <= in_w;
      end
      if (state_ff == ST_SCALE) begin
         scale_ff[0] <= scale_axis(SC_W'(u_ff), size_x, '0);
         scale_ff[1] <= scale_axis(SC_W'(ONE_Q) - SC_W'(v_ff), size_y, BIAS_W'(V_BIAS));
         scale_ff[2] <= scale_axis(SC_W'(w_ff), size_z, '0);
         for (int c = 0; c < CHAN_N; c++) begin
            chan_ff[c] <= '0;
         end
      end
      if (state_ff == ST_WRAP) begin
         idx_i_ff <= wrap_i[DIM_W-1:0];
         idx_j_ff <= wrap_j[DIM_W-1:0];
         idx_k_ff <= wrap_k[DIM_W-1:0];
         hit_ff <= wrap_i[DIM_W] | wrap_j[DIM_W] | wrap_k[DIM_W];
      end
      if (state_ff == ST_ROW) begin
         row_ff <= ADDR_W'(idx_k_ff) * ADDR_W'(size_y) + ADDR_W'(idx_j_ff);
      end
      if (state_ff == ST_ADDR) begin
         texel_ff <= row_ff * ADDR_W'(size_x) + ADDR_W'(idx_i_ff);
         cnt_ff <= '0;
      end
      if (rd_issue) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      rd_chan_ff <= cnt_ff[1:0];
      if (rd_pend_ff) begin
         chan_ff[rd_chan_ff] <= rd_data_ff & mask;
      end
      if (out_load) begin
         rsp_data_ff <= {chan_ff[3], chan_ff[2], chan_ff[1], chan_ff[0]};
         rsp_hit_ff <= hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= rd_issue;
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_hit_ff;

   `TNS_ASSERT_NOW(a_border_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "border result not zero")
   `TNS_ASSERT_NOW(a_read_count, state_ff == ST_READ, cnt_ff < chans, "read beyond channel count")
   `TNS_ASSERT_NOW(a_write_no_read, mem_we, !rd_pend_ff && !rd_issue, "store write during read")
   `TNS_ASSERT_NEXT(a_result_loaded, out_load, rsp_tvalid, "result not presented")

endmodule

`default_nettype wire

FILE: bench/tb_texture_nearest_sampler_wrap.sv
// Self-checking testbench for the nearest texel sampler with per-axis wrap modes
`timescale 1ns / 1ps

module tb_texture_nearest_sampler_wrap;
   import tns_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_ITEMS    = 95;

   typedef struct packed {
      bit [DIM_W-1:0] w;
      bit [DIM_W-1:0] h;
      bit [DIM_W-1:0] d;
      bit [1:0]       ws;
      bit [1:0]       wt;
      bit [1:0]       wr;
      bit [CNT_W-1:0] cc;
      bit [1:0]       kind;
   } sampler_cfg_type;

   class texel_predictor;
      typedef struct packed {
         bit                         border;
         bit [CHAN_N-1:0][ELEM_W-1:0] chan;
      } texel_type;

      bit [ELEM_W-1:0] texel_mem [STORE_ELEMENTS_DEF];
      bit              written [STORE_ELEMENTS_DEF];
      bit [DIM_W-1:0]  width_reg, height_reg, depth_reg;
      bit [1:0]        wrap_s, wrap_t, wrap_r, kind;
      bit [CNT_W-1:0]  chan_count;
      texel_type       expected_texels [$];
      int              errors;

      function new();
         width_reg  = 1;
         height_reg = 1;
         depth_reg  = 1;
         wrap_s     = WRAP_REPEAT;
         wrap_t     = WRAP_REPEAT;
         wrap_r     = WRAP_REPEAT;
         chan_count = 4;
         kind       = KIND_8BIT;
         errors     = 0;
      endfunction

      function void set_register(csr_index_type idx, bit [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_TEX_WIDTH:     width_reg  = value;
            CSR_TEX_HEIGHT:    height_reg = value;
            CSR_TEX_DEPTH:     depth_reg  = value;
            CSR_WRAP_S:        wrap_s     = value[1:0];
            CSR_WRAP_T:        wrap_t     = value[1:0];
            CSR_WRAP_R:        wrap_r     = value[1:0];
            CSR_CHANNEL_COUNT: chan_count = value[CNT_W-1:0];
            CSR_ELEMENT_KIND:  kind       = value[1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_texels.size();
      endfunction

      function bit [ELEM_W-1:0] kind_mask();
         case (kind)
            KIND_8BIT:  return 32'h0000_00FF;
            KIND_16BIT: return 32'h0000_FFFF;
            default:    return 32'hFFFF_FFFF;
         endcase
      endfunction

      function longint dim_of(bit [DIM_W-1:0] r);
         if (r == 0) return 1;
         if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
         return longint'(r);
      endfunction

      function longint wrap_index(longint x, longint n, bit [1:0] mode, inout bit hit);
         longint p;
         case (wrap_mode_type'(mode))
            WRAP_REPEAT: begin
               p = x % n;
               if (p < 0) p += n;
               return p;
            end
            WRAP_MIRROR: begin
               p = x % (2 * n);
               if (p < 0) p += 2 * n;
               if (p >= n) p = 2 * n - 1 - p;
               return p;
            end
            WRAP_CLAMP: begin
               if (x < 0) return 0;
               if (x > n - 1) return n - 1;
               return x;
            end
            default: begin
               if (x < 0 || x > n - 1) begin
                  hit = 1'b1;
                  return 0;
               end
               return x;
            end
         endcase
      endfunction

      // element addresses a sample reads under the current registers
      function void sample_addrs(bit [REQ_DATA_W-1:0] payload, ref bit [15:0] addrs [$],
                                 output bit hit);
         longint          w, h, d, i, j, k, u, v, z;
         longint unsigned base;
         int              cc;
         addrs.delete();
         w = dim_of(width_reg);
         h = dim_of(height_reg);
         d = dim_of(depth_reg);
         u = longint'($signed(payload[71:48]));
         v = longint'($signed(payload[95:72]));
         z = longint'($signed(payload[119:96]));
         i = (u * w) / 65536;
         j = ((65536 - v) * h - V_BIAS) / 65536;
         k = (z * d) / 65536;
         hit = 1'b0;
         i = wrap_index(i, w, wrap_s, hit);
         j = wrap_index(j, h, wrap_t, hit);
         k = wrap_index(k, d, wrap_r, hit);
         if (hit) return;
         cc = (chan_count > 4) ? 4 : int'(chan_count);
         base = longint'(((k * h + j) * w + i) * cc);
         for (int c = 0; c < cc; c++) addrs.push_back(16'(base + longint'(c)));
      endfunction

      function void note_request(func_type f, bit [REQ_DATA_W-1:0] payload);
         bit [15:0]       addrs [$];
         bit              hit;
         bit [ELEM_W-1:0] m;
         texel_type       t;
         m = kind_mask();
         if (f == FUNC_WRITE) begin
            texel_mem[payload[15:0]] = payload[47:16] & m;
            written[payload[15:0]] = 1'b1;
            return;
         end
         sample_addrs(payload, addrs, hit);
         t = '0;
         t.border = hit;
         foreach (addrs[c]) t.chan[c] = texel_mem[addrs[c]] & m;
         expected_texels.push_back(t);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] payload, logic border_flag);
         texel_type t;
         if (expected_texels.size() == 0) begin
            $display("%0t: unexpected result chan=%h border=%b", $time, payload, border_flag);
            errors++;
            return;
         end
         t = expected_texels.pop_front();
         for (int c = 0; c < CHAN_N; c++) begin
            if (payload[c*ELEM_W +: ELEM_W] !== t.chan[c]) begin
               $display("%0t: chan%0d mismatch expected %h actual %h",
                        $time, c, t.chan[c], payload[c*ELEM_W +: ELEM_W]);
               errors++;
            end
         end
         if (border_flag !== t.border) begin
            $display("%0t: border_hit mismatch expected %b actual %b",
                     $time, t.border, border_flag);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   texel_predictor predictor = new();
   bit             no_idle = 1'b0;
   bit             hold_off_req = 1'b0;
   int             stall_cycles = 0;
   int             items_sent = 0;

   texture_nearest_sampler_wrap i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) predictor.check_response(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("texture_nearest_sampler_wrap test failed");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= no_idle || ($urandom_range(99) >= 22);
      end
   end

   task automatic send_item(input func_type f, input bit [REQ_DATA_W-1:0] payload);
      if (!no_idle) begin
         while ($urandom_range(99) < 22) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= payload;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predictor.note_request(f, payload);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_write(input bit [15:0] idx, input bit [31:0] value);
      bit [71:0] junk;
      junk = ($urandom_range(1) == 0) ? '0 : 72'({$urandom, $urandom, $urandom});
      send_item(FUNC_WRITE, {junk, value, idx});
   endtask

   // write any element the sample would read before it has been written
   task automatic send_sample(input bit [23:0] u, input bit [23:0] v, input bit [23:0] z);
      bit [REQ_DATA_W-1:0] payload;
      bit [15:0]           addrs [$];
      bit                  hit;
      payload = {z, v, u, 32'($urandom), 16'($urandom)};
      predictor.sample_addrs(payload, addrs, hit);
      foreach (addrs[c]) begin
         if (!predictor.written[addrs[c]]) send_write(addrs[c], $urandom);
      end
      send_item(FUNC_SAMPLE, payload);
   endtask

   // hold the input idle until every pending result has been transferred
   task automatic wait_results(input int settle);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (predictor.pending() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic program_regs(input sampler_cfg_type cfg);
      bit [CSR_DATA_W-1:0] vals [8];
      bit [CSR_DATA_W-1:0] keep;
      bit [CSR_DATA_W-1:0] wdata;
      vals[0] = cfg.w;
      vals[1] = cfg.h;
      vals[2] = cfg.d;
      vals[3] = CSR_DATA_W'(cfg.ws);
      vals[4] = CSR_DATA_W'(cfg.wt);
      vals[5] = CSR_DATA_W'(cfg.wr);
      vals[6] = CSR_DATA_W'(cfg.cc);
      vals[7] = CSR_DATA_W'(cfg.kind);
      wait_results(SETTLE_CYCLES);
      for (int r = 0; r < 8; r++) begin
         keep  = (r < 3) ? 11'h7FF : (r == 6) ? 11'h007 : 11'h003;
         wdata = vals[r];
         if ($urandom_range(3) == 0) wdata = wdata | (11'($urandom) & ~keep);
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(r);
         csr_wdata <= wdata;
         predictor.set_register(csr_index_type'(r), wdata);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic sampler_cfg_type make_cfg(input int w, input int h, input int d,
                                                input int ws, input int wt, input int wr,
                                                input int cc, input int kind);
      sampler_cfg_type cfg;
      cfg.w    = DIM_W'(w);
      cfg.h    = DIM_W'(h);
      cfg.d    = DIM_W'(d);
      cfg.ws   = 2'(ws);
      cfg.wt   = 2'(wt);
      cfg.wr   = 2'(wr);
      cfg.cc   = CNT_W'(cc);
      cfg.kind = 2'(kind);
      return cfg;
   endfunction

   function automatic bit [DIM_W-1:0] random_dim();
      int sel;
      sel = $urandom_range(99);
      if (sel < 65) return DIM_W'($urandom_range(16, 1));
      if (sel < 75) return DIM_W'($urandom_range(64, 17));
      if (sel < 82) return 0;
      if (sel < 88) return DIM_W'(MAX_DIM_DEF);
      if (sel < 94) return DIM_W'($urandom_range(2047, MAX_DIM_DEF + 1));
      return DIM_W'($urandom_range(MAX_DIM_DEF, 1));
   endfunction

   function automatic bit [23:0] random_coord();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'($urandom_range(65535));
         2: return 24'($urandom_range(196608) - 131072);
         default: begin
            case ($urandom_range(5))
               0: return 24'h800000;
               1: return 24'h7FFFFF;
               2: return 24'h000000;
               3: return 24'h010000;
               4: return 24'h00FFFF;
               default: return 24'hFFFFFF;
            endcase
         end
      endcase
   endfunction

   task automatic random_item();
      bit [31:0] value;
      if ($urandom_range(99) < 20) begin
         case ($urandom_range(7))
            0: value = 32'h0000_0000;
            1: value = 32'hFFFF_FFFF;
            default: value = $urandom;
         endcase
         send_write(16'($urandom), value);
      end else begin
         send_sample(random_coord(), random_coord(), random_coord());
      end
   endtask

   initial begin
      sampler_cfg_type cfg;
      int              phase_end;
      int              n;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      program_regs(make_cfg(4, 4, 2, WRAP_REPEAT, WRAP_REPEAT, WRAP_REPEAT, 4, KIND_32BIT));
      send_write(16'h0000, 32'hFFFF_FFFF);
      send_write(16'hFFFF, 32'h0000_0000);
      send_sample(24'h000000, 24'h000000, 24'h000000);
      send_sample(24'h7FFFFF, 24'h800000, 24'h800000);
      send_sample(24'h800000, 24'h7FFFFF, 24'h7FFFFF);
      send_sample(24'h00FFFF, 24'h010000, 24'h010000);

      // narrower kind over full-width data, channel count above four
      program_regs(make_cfg(4, 4, 2, WRAP_MIRROR, WRAP_MIRROR, WRAP_MIRROR, 7, KIND_8BIT));
      send_sample(24'h000000, 24'h010000, 24'h000000);
      send_sample(24'hFF0000, 24'h030000, 24'hFE8000);
      send_sample(24'h800000, 24'h7FFFFF, 24'h7FFFFF);

      // zero sizes, no channels, kind three
      program_regs(make_cfg(0, 0, 0, WRAP_CLAMP, WRAP_CLAMP, WRAP_CLAMP, 0, 3));
      send_sample(24'h7FFFFF, 24'h800000, 24'hFFFFFF);
      send_sample(24'h008000, 24'h008000, 24'h008000);
      program_regs(make_cfg(5, 3, 1, WRAP_CLAMP, WRAP_CLAMP, WRAP_CLAMP, 2, 3));
      send_sample(24'hFFFFFF, 24'h7FFFFF, 24'h020000);

      // oversize sizes, border inside and outside
      program_regs(make_cfg(2047, 2047, 2047, WRAP_BORDER, WRAP_BORDER, WRAP_BORDER,
                            1, KIND_16BIT));
      send_sample(24'h000000, 24'h010000, 24'h000000);
      send_sample(24'h00FFFF, 24'h000001, 24'h00FFFF);
      send_sample(24'hFFFFFF, 24'h008000, 24'h008000);
      send_sample(24'h008000, 24'h010001, 24'h010000);

      // mixed modes with addresses past the end of the store
      program_regs(make_cfg(1024, 1024, 1024, WRAP_BORDER, WRAP_REPEAT, WRAP_MIRROR,
                            3, KIND_32BIT));
      send_sample(24'h00FFFF, 24'h000000, 24'h00FFFF);
      send_sample(24'h00C000, 24'h7FFFFF, 24'h800000);
      send_sample(24'h010000, 24'h004000, 24'h020000);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         cfg.w    = random_dim();
         cfg.h    = random_dim();
         cfg.d    = ($urandom_range(2) == 0) ? 11'd1 : random_dim();
         cfg.ws   = 2'($urandom_range(3));
         cfg.wt   = 2'($urandom_range(3));
         cfg.wr   = 2'($urandom_range(3));
         cfg.cc   = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
         cfg.kind = 2'($urandom_range(3));
         program_regs(cfg);
         no_idle = (p == 4);
         phase_end = items_sent + PHASE_ITEMS;
         n = 0;
         while (items_sent < phase_end) begin
            if (p == 6 && n == 5) hold_off_req = 1'b1;
            if (p == 9 && n == 10) wait_results(0);
            random_item();
            n++;
         end
         no_idle = 1'b0;
      end

      wait_results(SETTLE_CYCLES);
      if (predictor.errors == 0 && predictor.pending() == 0) begin
         $display("texture_nearest_sampler_wrap test passed");
      end else begin
         $display("texture_nearest_sampler_wrap test failed");
      end
      $finish;
   end

endmodule
